### hw/rtl/cpt_pkg.sv
// cpt_pkg: word types, coordinate width and region codes for the closest point on triangle block
// no dependencies; imported by closest_point_on_triangle
package cpt_pkg;

  localparam int unsigned CoordW = 32;

  typedef logic signed [CoordW-1:0] coord_t;

  typedef enum logic [2:0] {
    RegVertA  = 3'd0,
    RegVertB  = 3'd1,
    RegEdgeAb = 3'd2,
    RegVertC  = 3'd3,
    RegEdgeAc = 3'd4,
    RegEdgeBc = 3'd5,
    RegFace   = 3'd6,
    RegDegen  = 3'd7
  } region_e;

  typedef struct packed {
    coord_t point_x;
    coord_t point_y;
    coord_t point_z;
    coord_t vertex_a_x;
    coord_t vertex_a_y;
    coord_t vertex_a_z;
    coord_t vertex_b_x;
    coord_t vertex_b_y;
    coord_t vertex_b_z;
    coord_t vertex_c_x;
    coord_t vertex_c_y;
    coord_t vertex_c_z;
  } cpt_in_t;

  typedef struct packed {
    coord_t  closest_x;
    coord_t  closest_y;
    coord_t  closest_z;
    region_e region;
  } cpt_out_t;

endpackage

### hw/rtl/closest_point_on_triangle.sv
// closest_point_on_triangle: pipelined nearest point on a triangle with voronoi region code
// depends on cpt_pkg (word types, region codes)
//
//   channel | handshake              | word
//   --------+------------------------+---------------------------------
//   in      | in_valid_i, in_ready_o | in_data_i  (cpt_pkg::cpt_in_t)
//   out     | out_valid_o, out_ready_i | out_data_o (cpt_pkg::cpt_out_t)
//
// one word accepted per cycle unless every stage is full and the output is stalled
// the two lane restoring divider produces one quotient bit per stage
// reset clears only the stage valid bits
// each stage holds while the next one is full, so bubbles close up under a stall
// and a word is taken in while a finished result waits at the output
module closest_point_on_triangle #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  cpt_pkg::cpt_in_t   in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output cpt_pkg::cpt_out_t  out_data_o
);
  import cpt_pkg::*;

  localparam int unsigned CW  = CoordW;
  localparam int unsigned DW  = CW + 1;
  localparam int unsigned PW  = 2 * DW;
  localparam int unsigned DDW = PW + 2;
  localparam int unsigned LW  = DDW / 2;
  localparam int unsigned HW  = DDW - LW;
  localparam int unsigned PPW = 2 * (HW + 1);
  localparam int unsigned VPW = 2 * DDW;
  localparam int unsigned VW  = VPW + 1;
  localparam int unsigned NW  = VW + 2;
  localparam int unsigned RW  = NW + 1;
  localparam int unsigned TW  = FRAC_BITS + 1;
  localparam int unsigned SW  = TW + 1 + DW;
  localparam int unsigned AW  = CW + 3;

  localparam int unsigned ST_DIF = 1;
  localparam int unsigned ST_MUL = 2;
  localparam int unsigned ST_DOT = 3;
  localparam int unsigned ST_PP  = 4;
  localparam int unsigned ST_VP  = 5;
  localparam int unsigned ST_V   = 6;
  localparam int unsigned ST_SEL = 7;
  localparam int unsigned ST_CHK = 8;
  localparam int unsigned ST_TE  = ST_CHK + FRAC_BITS + 1;
  localparam int unsigned ST_ADD = ST_TE + 1;
  localparam int unsigned NSTG   = ST_ADD + 1;

  // operand pairs of the six cross products: d1*d4, d3*d2, d5*d2, d1*d6, d3*d6, d5*d4
  localparam int unsigned MulL [6] = '{0, 2, 4, 0, 2, 4};
  localparam int unsigned MulR [6] = '{3, 1, 1, 5, 5, 3};

  typedef struct packed {
    logic [2:0][CW-1:0] a;
    logic [2:0][CW-1:0] b;
    logic [2:0][CW-1:0] c;
    logic [2:0][DW-1:0] ab;
    logic [2:0][DW-1:0] ac;
    logic [2:0][DW-1:0] bc;
  } geo_t;

  typedef struct packed {
    geo_t               geo;
    logic [2:0][DW-1:0] ap;
    logic [2:0][DW-1:0] bp;
    logic [2:0][DW-1:0] cp;
  } dif_t;

  typedef struct packed {
    geo_t                geo;
    logic [17:0][PW-1:0] prd;
  } mul_t;

  typedef struct packed {
    geo_t               geo;
    logic [5:0][DDW-1:0] d;
  } dot_t;

  typedef struct packed {
    geo_t                     geo;
    logic [5:0][DDW-1:0]      d;
    logic [5:0][3:0][PPW-1:0] pp;
  } pp_t;

  typedef struct packed {
    geo_t                geo;
    logic [5:0][DDW-1:0] d;
    logic [5:0][VPW-1:0] m;
  } vp_t;

  typedef struct packed {
    geo_t                geo;
    logic [5:0][DDW-1:0] d;
    logic [VW-1:0]       va;
    logic [VW-1:0]       vb;
    logic [VW-1:0]       vc;
  } v_t;

  typedef struct packed {
    region_e            region;
    logic [2:0][CW-1:0] base;
    logic [2:0][DW-1:0] e1;
    logic [2:0][DW-1:0] e2;
    logic [1:0][NW-1:0] num;
    logic [NW-1:0]      den;
    logic [1:0]         clr;
  } sel_t;

  typedef struct packed {
    region_e                   region;
    logic [2:0][CW-1:0]        base;
    logic [2:0][DW-1:0]        e1;
    logic [2:0][DW-1:0]        e2;
    logic [NW-1:0]             den;
    logic [1:0]                fix;
    logic [1:0]                one;
    logic [1:0][RW-1:0]        rem;
    logic [1:0][FRAC_BITS-1:0] quo;
  } div_t;

  typedef struct packed {
    region_e                 region;
    logic [2:0][CW-1:0]      base;
    logic [1:0][2:0][SW-1:0] prd;
  } te_t;

  typedef struct packed {
    region_e            region;
    logic [2:0][AW-1:0] res;
  } add_t;

  function automatic logic signed [PW-1:0] mul_dd(input logic signed [DW-1:0] x,
                                                  input logic signed [DW-1:0] y);
    return x * y;
  endfunction

  function automatic logic signed [PPW-1:0] mul_pp(input logic signed [HW:0] x,
                                                   input logic signed [HW:0] y);
    return x * y;
  endfunction

  function automatic logic signed [SW-1:0] mul_te(input logic signed [TW:0] t,
                                                  input logic signed [DW-1:0] e);
    return t * e;
  endfunction

  function automatic logic [CW-1:0] sat_crd(input logic [AW-1:0] x);
    logic [AW-CW:0] top;
    top = x[AW-1:CW-1];
    if ((&top) || !(|top)) begin
      return x[CW-1:0];
    end else if (x[AW-1]) begin
      return {1'b1, {(CW-1){1'b0}}};
    end else begin
      return {1'b0, {(CW-1){1'b1}}};
    end
  endfunction

  // stage control
  logic [NSTG:1]   vld_q, vld_d;
  logic [NSTG+1:1] en;

  always_comb begin
    en[NSTG+1] = out_ready_i;
    for (int k = NSTG; k >= 1; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
    vld_d = (vld_q & ~en[NSTG:1]) | ({vld_q[NSTG-1:1], in_valid_i} & en[NSTG:1]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_ready_o  = en[1];
  assign out_valid_o = vld_q[NSTG];

  dif_t     stg1_q, stg1_d;
  mul_t     stg2_q, stg2_d;
  dot_t     stg3_q, stg3_d;
  pp_t      stg4_q, stg4_d;
  vp_t      stg5_q, stg5_d;
  v_t       stg6_q, stg6_d;
  sel_t     stg7_q, stg7_d;
  div_t     chk_d;
  div_t     dv_q [FRAC_BITS+1];
  div_t     dv_d [FRAC_BITS+1];
  te_t      te_q, te_d;
  add_t     add_q, add_d;
  cpt_out_t out_q, out_d;

  // edge and offset vectors
  always_comb begin
    logic signed [CW-1:0] pv [3];
    logic signed [CW-1:0] av [3];
    logic signed [CW-1:0] bv [3];
    logic signed [CW-1:0] cv [3];
    pv[0] = in_data_i.point_x;    pv[1] = in_data_i.point_y;    pv[2] = in_data_i.point_z;
    av[0] = in_data_i.vertex_a_x; av[1] = in_data_i.vertex_a_y; av[2] = in_data_i.vertex_a_z;
    bv[0] = in_data_i.vertex_b_x; bv[1] = in_data_i.vertex_b_y; bv[2] = in_data_i.vertex_b_z;
    cv[0] = in_data_i.vertex_c_x; cv[1] = in_data_i.vertex_c_y; cv[2] = in_data_i.vertex_c_z;
    for (int k = 0; k < 3; k++) begin
      stg1_d.geo.a[k]  = av[k];
      stg1_d.geo.b[k]  = bv[k];
      stg1_d.geo.c[k]  = cv[k];
      stg1_d.geo.ab[k] = DW'(bv[k]) - DW'(av[k]);
      stg1_d.geo.ac[k] = DW'(cv[k]) - DW'(av[k]);
      stg1_d.geo.bc[k] = DW'(cv[k]) - DW'(bv[k]);
      stg1_d.ap[k]     = DW'(pv[k]) - DW'(av[k]);
      stg1_d.bp[k]     = DW'(pv[k]) - DW'(bv[k]);
      stg1_d.cp[k]     = DW'(pv[k]) - DW'(cv[k]);
    end
  end

  // per axis products of the six dot products
  always_comb begin
    stg2_d.geo = stg1_q.geo;
    for (int k = 0; k < 3; k++) begin
      stg2_d.prd[k]      = mul_dd($signed(stg1_q.ap[k]), $signed(stg1_q.geo.ab[k]));
      stg2_d.prd[3 + k]  = mul_dd($signed(stg1_q.ap[k]), $signed(stg1_q.geo.ac[k]));
      stg2_d.prd[6 + k]  = mul_dd($signed(stg1_q.bp[k]), $signed(stg1_q.geo.ab[k]));
      stg2_d.prd[9 + k]  = mul_dd($signed(stg1_q.bp[k]), $signed(stg1_q.geo.ac[k]));
      stg2_d.prd[12 + k] = mul_dd($signed(stg1_q.cp[k]), $signed(stg1_q.geo.ab[k]));
      stg2_d.prd[15 + k] = mul_dd($signed(stg1_q.cp[k]), $signed(stg1_q.geo.ac[k]));
    end
  end

  always_comb begin
    stg3_d.geo = stg2_q.geo;
    for (int j = 0; j < 6; j++) begin
      stg3_d.d[j] = DDW'($signed(stg2_q.prd[3*j])) + DDW'($signed(stg2_q.prd[3*j + 1]))
                  + DDW'($signed(stg2_q.prd[3*j + 2]));
    end
  end

  // split cross products into half width partial products
  always_comb begin
    logic [DDW-1:0]    x, y;
    logic signed [HW:0] xh, xl, yh, yl;
    stg4_d.geo = stg3_q.geo;
    stg4_d.d   = stg3_q.d;
    for (int m = 0; m < 6; m++) begin
      x  = stg3_q.d[MulL[m]];
      y  = stg3_q.d[MulR[m]];
      xh = {x[DDW-1], x[DDW-1:LW]};
      yh = {y[DDW-1], y[DDW-1:LW]};
      xl = {{(HW + 1 - LW){1'b0}}, x[LW-1:0]};
      yl = {{(HW + 1 - LW){1'b0}}, y[LW-1:0]};
      stg4_d.pp[m][0] = mul_pp(xh, yh);
      stg4_d.pp[m][1] = mul_pp(xh, yl);
      stg4_d.pp[m][2] = mul_pp(xl, yh);
      stg4_d.pp[m][3] = mul_pp(xl, yl);
    end
  end

  always_comb begin
    stg5_d.geo = stg4_q.geo;
    stg5_d.d   = stg4_q.d;
    for (int m = 0; m < 6; m++) begin
      stg5_d.m[m] = (VPW'($signed(stg4_q.pp[m][0])) <<< (2 * LW))
                  + ((VPW'($signed(stg4_q.pp[m][1])) + VPW'($signed(stg4_q.pp[m][2]))) <<< LW)
                  + VPW'($signed(stg4_q.pp[m][3]));
    end
  end

  always_comb begin
    stg6_d.geo = stg5_q.geo;
    stg6_d.d   = stg5_q.d;
    stg6_d.vc  = VW'($signed(stg5_q.m[0])) - VW'($signed(stg5_q.m[1]));
    stg6_d.vb  = VW'($signed(stg5_q.m[2])) - VW'($signed(stg5_q.m[3]));
    stg6_d.va  = VW'($signed(stg5_q.m[4])) - VW'($signed(stg5_q.m[5]));
  end

  // region tests and divider operands
  always_comb begin
    logic signed [DDW-1:0] d [6];
    logic signed [VW-1:0]  va, vb, vc;
    logic signed [NW-1:0]  nbc;
    for (int j = 0; j < 6; j++) begin
      d[j] = $signed(stg6_q.d[j]);
    end
    va  = $signed(stg6_q.va);
    vb  = $signed(stg6_q.vb);
    vc  = $signed(stg6_q.vc);
    nbc = NW'(d[3]) - NW'(d[2]);

    stg7_d.base   = stg6_q.geo.a;
    stg7_d.e1     = stg6_q.geo.ab;
    stg7_d.e2     = stg6_q.geo.ac;
    stg7_d.num[0] = '0;
    stg7_d.num[1] = '0;
    stg7_d.den    = '0;
    stg7_d.clr    = 2'b11;

    if (d[0] <= 0 && d[1] <= 0) begin
      stg7_d.region = RegVertA;
    end else if (d[2] >= 0 && d[3] <= d[2]) begin
      stg7_d.region = RegVertB;
      stg7_d.base   = stg6_q.geo.b;
    end else if (vc <= 0 && d[0] >= 0 && d[2] <= 0) begin
      stg7_d.region = RegEdgeAb;
      stg7_d.num[0] = NW'(d[0]);
      stg7_d.den    = NW'(d[0]) - NW'(d[2]);
      stg7_d.clr    = 2'b10;
    end else if (d[5] >= 0 && d[4] <= d[5]) begin
      stg7_d.region = RegVertC;
      stg7_d.base   = stg6_q.geo.c;
    end else if (vb <= 0 && d[1] >= 0 && d[5] <= 0) begin
      stg7_d.region = RegEdgeAc;
      stg7_d.e1     = stg6_q.geo.ac;
      stg7_d.num[0] = NW'(d[1]);
      stg7_d.den    = NW'(d[1]) - NW'(d[5]);
      stg7_d.clr    = 2'b10;
    end else if (va <= 0 && d[2] <= d[3] && d[5] <= d[4]) begin
      stg7_d.region = RegEdgeBc;
      stg7_d.base   = stg6_q.geo.b;
      stg7_d.e1     = stg6_q.geo.bc;
      stg7_d.num[0] = nbc;
      stg7_d.den    = nbc + NW'(d[4]) - NW'(d[5]);
      stg7_d.clr    = 2'b10;
    end else begin
      stg7_d.region = RegFace;
      stg7_d.num[0] = NW'(vb);
      stg7_d.num[1] = NW'(vc);
      stg7_d.den    = NW'(va) + NW'(vb) + NW'(vc);
      stg7_d.clr    = 2'b00;
    end
  end

  // clamp checks ahead of the divider
  always_comb begin
    logic signed [NW-1:0] den, num;
    logic                 zero, npos, dle;
    den           = $signed(stg7_q.den);
    zero          = (den == 0);
    chk_d.region  = stg7_q.region;
    chk_d.base    = stg7_q.base;
    chk_d.e1      = stg7_q.e1;
    chk_d.e2      = stg7_q.e2;
    chk_d.den     = stg7_q.den;
    chk_d.quo     = '0;
    if (stg7_q.region == RegFace && zero) begin
      chk_d.region = RegDegen;
    end
    for (int i = 0; i < 2; i++) begin
      num          = $signed(stg7_q.num[i]);
      npos         = (num > 0);
      dle          = (den <= num);
      chk_d.fix[i] = stg7_q.clr[i] || zero || !npos || dle;
      chk_d.one[i] = !stg7_q.clr[i] && !zero && npos && dle;
      chk_d.rem[i] = {1'b0, stg7_q.num[i]};
    end
  end

  // restoring divider, one quotient bit per stage in both lanes
  always_comb begin
    logic [RW-1:0] r2;
    logic          ge;
    dv_d[0] = chk_d;
    for (int j = 1; j <= FRAC_BITS; j++) begin
      dv_d[j] = dv_q[j-1];
      for (int i = 0; i < 2; i++) begin
        r2             = {dv_q[j-1].rem[i][RW-2:0], 1'b0};
        ge             = (r2 >= {1'b0, dv_q[j-1].den});
        dv_d[j].rem[i] = ge ? r2 - {1'b0, dv_q[j-1].den} : r2;
        dv_d[j].quo[i] = {dv_q[j-1].quo[i][FRAC_BITS-2:0], ge};
      end
    end
  end

  always_comb begin
    logic [TW-1:0] t;
    te_d.region = dv_q[FRAC_BITS].region;
    te_d.base   = dv_q[FRAC_BITS].base;
    for (int i = 0; i < 2; i++) begin
      if (dv_q[FRAC_BITS].fix[i]) begin
        t = dv_q[FRAC_BITS].one[i] ? {1'b1, {FRAC_BITS{1'b0}}} : '0;
      end else begin
        t = {1'b0, dv_q[FRAC_BITS].quo[i]};
      end
      for (int k = 0; k < 3; k++) begin
        te_d.prd[i][k] = mul_te($signed({1'b0, t}),
                                $signed(i == 0 ? dv_q[FRAC_BITS].e1[k]
                                               : dv_q[FRAC_BITS].e2[k]));
      end
    end
  end

  always_comb begin
    add_d.region = te_q.region;
    for (int k = 0; k < 3; k++) begin
      add_d.res[k] = AW'($signed(te_q.base[k]))
                   + AW'($signed(te_q.prd[0][k]) >>> FRAC_BITS)
                   + AW'($signed(te_q.prd[1][k]) >>> FRAC_BITS);
    end
  end

  always_comb begin
    out_d.closest_x = sat_crd(add_q.res[0]);
    out_d.closest_y = sat_crd(add_q.res[1]);
    out_d.closest_z = sat_crd(add_q.res[2]);
    out_d.region    = add_q.region;
  end

  always_ff @(posedge clk_i) begin
    if (en[ST_DIF]) begin
      stg1_q <= stg1_d;
    end
    if (en[ST_MUL]) begin
      stg2_q <= stg2_d;
    end
    if (en[ST_DOT]) begin
      stg3_q <= stg3_d;
    end
    if (en[ST_PP]) begin
      stg4_q <= stg4_d;
    end
    if (en[ST_VP]) begin
      stg5_q <= stg5_d;
    end
    if (en[ST_V]) begin
      stg6_q <= stg6_d;
    end
    if (en[ST_SEL]) begin
      stg7_q <= stg7_d;
    end
    for (int j = 0; j <= FRAC_BITS; j++) begin
      if (en[ST_CHK + j]) begin
        dv_q[j] <= dv_d[j];
      end
    end
    if (en[ST_TE]) begin
      te_q <= te_d;
    end
    if (en[ST_ADD]) begin
      add_q <= add_d;
    end
    if (en[NSTG]) begin
      out_q <= out_d;
    end
  end

  assign out_data_o = out_q;

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (&vld_q) && !out_ready_i)
    else $error("input stalled with a bubble in the pipeline");

  a_degen_clears_both: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[ST_CHK] && dv_q[0].region == RegDegen |-> dv_q[0].fix == 2'b11 && dv_q[0].one == 2'b00)
    else $error("degenerate triangle not mapped to vertex a");

  a_one_needs_fix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[ST_CHK] |-> (dv_q[0].one & ~dv_q[0].fix) == 2'b00)
    else $error("full scale parameter without clamp flag");

  a_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[ST_CHK + FRAC_BITS] && !dv_q[FRAC_BITS].fix[0]
      |-> dv_q[FRAC_BITS].rem[0] < {1'b0, dv_q[FRAC_BITS].den})
    else $error("divider remainder out of range");

  a_vertex_no_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[ST_SEL] && (stg7_q.region == RegVertA || stg7_q.region == RegVertB ||
                      stg7_q.region == RegVertC) |-> stg7_q.clr == 2'b11)
    else $error("vertex region with an edge step enabled");

endmodule
